// ===== sv/atrm_pkg.sv =====
// shared types and constants of the modem reply line matcher
// no dependencies; used by atrm_tail_cmp and at_reply_line_matcher
package atrm_pkg;

  localparam int LINE_BYTES   = 256;
  localparam int WINDOW_BYTES = 16;
  localparam int LINE_W       = $clog2(LINE_BYTES + 1);
  localparam int NUM_ENTRIES  = 9;
  localparam int NUM_FIXED    = 8;
  localparam int USER_ENTRY   = 8;
  localparam int MAX_PAT      = 16;
  localparam int PAT_LEN_W    = 5;
  localparam int CFG_W        = 64;
  localparam int REG_IDX_W    = 2;

  localparam logic [7:0] CH_PROMPT = 8'h3e;
  localparam logic [7:0] CH_CR     = 8'h0d;
  localparam logic [7:0] CH_LF     = 8'h0a;
  localparam logic [7:0] CH_COLON  = 8'h3a;

  // register indexes of the write port
  localparam logic [REG_IDX_W-1:0] REG_DATA_MODE = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_USER_HEAD = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_USER_TAIL = 2'd2;
  localparam logic [REG_IDX_W-1:0] REG_USER_LEN  = 2'd3;

  // request kinds
  localparam logic REQ_BYTE  = 1'b0;
  localparam logic REQ_CLEAR = 1'b1;

  typedef enum logic [1:0] {
    ST_NONE = 2'd0,
    ST_OK   = 2'd1,
    ST_ERR  = 2'd2
  } reply_code_t;

  // patterns as string literals: last character sits in the low byte,
  // so byte k lines up with the k-th newest window byte
  typedef logic [8*MAX_PAT-1:0] pat_t;

  localparam pat_t FIXED_PAT [NUM_FIXED] = '{
    "OK", "SMS Ready", "CONNECT OK", ">", "SEND OK", "SHUT OK", "CONNECT OK", "OK"
  };
  localparam logic [PAT_LEN_W-1:0] FIXED_LEN [NUM_FIXED] = '{
    5'd2, 5'd9, 5'd10, 5'd1, 5'd7, 5'd7, 5'd10, 5'd2
  };
  localparam pat_t                 ERR_PAT = "ERROR";
  localparam logic [PAT_LEN_W-1:0] ERR_LEN = 5'd5;

  typedef logic [WINDOW_BYTES-1:0][7:0] window_t;

  typedef struct packed {
    logic [NUM_ENTRIES-1:0] seen;
    logic                   err;
    logic [NUM_ENTRIES-1:0] prompt_mask;
  } hit_t;

  typedef struct packed {
    logic       req_type;
    logic [7:0] rx_byte;
    logic [3:0] entry_index;
  } req_t;

  typedef struct packed {
    logic [2*NUM_ENTRIES-1:0] reply_states;
    logic                     line_done;
    logic                     prompt_seen;
    logic                     hex_line;
    logic [NUM_ENTRIES-1:0]   matched_mask;
  } rsp_t;

endpackage

// ===== sv/atrm_tail_cmp.sv =====
// window comparators: checks the newest line bytes against every expected reply
// depends on atrm_pkg
module atrm_tail_cmp (
  input  atrm_pkg::window_t                   win,
  input  logic [atrm_pkg::LINE_W-1:0]         line_len,
  input  atrm_pkg::pat_t                      user_pat,
  input  logic [atrm_pkg::PAT_LEN_W-1:0]      user_len,
  output atrm_pkg::hit_t                      hit
);

  logic [atrm_pkg::LINE_W-1:0]   user_len_ext;
  logic [atrm_pkg::LINE_W-1:0]   err_len_ext;
  logic [atrm_pkg::NUM_FIXED-1:0] fixed_ok;
  logic                          user_ok;
  logic                          err_ok;
  logic [atrm_pkg::PAT_LEN_W-1:0] uidx;

  assign user_len_ext = atrm_pkg::LINE_W'(user_len);
  assign err_len_ext  = atrm_pkg::LINE_W'(atrm_pkg::ERR_LEN);

  // fixed entries: constant patterns, newest byte against last character
  always_comb begin
    for (int i = 0; i < atrm_pkg::NUM_FIXED; i++) begin
      fixed_ok[i] = (atrm_pkg::FIXED_LEN[i] != '0)
                    && (int'(atrm_pkg::FIXED_LEN[i]) <= atrm_pkg::WINDOW_BYTES)
                    && (atrm_pkg::LINE_W'(atrm_pkg::FIXED_LEN[i]) <= line_len);
      for (int k = 0; k < atrm_pkg::WINDOW_BYTES; k++) begin
        if (k < int'(atrm_pkg::FIXED_LEN[i]) && k < atrm_pkg::MAX_PAT) begin
          if (win[k] != atrm_pkg::FIXED_PAT[i][8*k +: 8]) fixed_ok[i] = 1'b0;
        end
      end
    end
  end

  always_comb begin
    err_ok = (err_len_ext <= line_len);
    for (int k = 0; k < atrm_pkg::WINDOW_BYTES; k++) begin
      if (k < int'(atrm_pkg::ERR_LEN) && k < atrm_pkg::MAX_PAT) begin
        if (win[k] != atrm_pkg::ERR_PAT[8*k +: 8]) err_ok = 1'b0;
      end
    end
  end

  // user entry: first character in the low byte, so index runs backward
  always_comb begin
    user_ok = (user_len != '0)
              && (int'(user_len) <= atrm_pkg::WINDOW_BYTES)
              && (user_len_ext <= line_len);
    uidx = '0;
    for (int k = 0; k < atrm_pkg::WINDOW_BYTES; k++) begin
      if (k < int'(user_len)) begin
        uidx = user_len - 5'd1 - atrm_pkg::PAT_LEN_W'(k);
        if (win[k] != user_pat[8*uidx[3:0] +: 8]) user_ok = 1'b0;
      end
    end
  end

  always_comb begin
    hit.seen = {user_ok, fixed_ok};
    hit.err  = err_ok;
    for (int i = 0; i < atrm_pkg::NUM_FIXED; i++) begin
      hit.prompt_mask[i] =
        (atrm_pkg::FIXED_PAT[i][8*(int'(atrm_pkg::FIXED_LEN[i]) - 1) +: 8]
         == atrm_pkg::CH_PROMPT);
    end
    hit.prompt_mask[atrm_pkg::USER_ENTRY] =
      (user_len != '0) && (user_pat[7:0] == atrm_pkg::CH_PROMPT);
  end

endmodule

// ===== sv/at_reply_line_matcher.sv =====
// Modem reply line matcher. Takes one request per cycle unless the output stalls:
// a received byte or a clear of one entry. Each accepted request yields one
// registered result; a new request is taken in the same cycle that the held
// result is transferred, so with rsp_ready high the rate is one item per clock.
// Line state and the sixteen-byte window update at the accept edge, and the
// window comparators run in that same cycle. Configuration writes apply at once.
module at_reply_line_matcher (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               req_valid,
  output logic                               req_ready,
  input  atrm_pkg::req_t                     req_data,
  output logic                               rsp_valid,
  input  logic                               rsp_ready,
  output atrm_pkg::rsp_t                     rsp_data,
  input  logic                               wr_en,
  input  logic [atrm_pkg::REG_IDX_W-1:0]     wr_index,
  input  logic [atrm_pkg::CFG_W-1:0]         wr_data
);

  localparam int NE = atrm_pkg::NUM_ENTRIES;

  // configuration
  logic                               data_mode;
  logic [63:0]                        user_head;
  logic [63:0]                        user_tail;
  logic [atrm_pkg::PAT_LEN_W-1:0]     user_len;
  logic [atrm_pkg::PAT_LEN_W-1:0]     user_len_cap;

  // line state
  atrm_pkg::window_t                  window;
  atrm_pkg::window_t                  window_next;
  atrm_pkg::window_t                  window_shift;
  logic [atrm_pkg::LINE_W-1:0]        line_length;
  logic [atrm_pkg::LINE_W-1:0]        line_length_next;
  logic [atrm_pkg::LINE_W-1:0]        len_inc;
  logic [7:0]                         first_char;
  logic [7:0]                         first_char_next;
  logic [NE-1:0]                      seen_flags;
  logic [NE-1:0]                      seen_flags_next;
  logic                               error_flag;
  logic                               error_flag_next;
  logic [NE-1:0][1:0]                 entry_state;
  logic [NE-1:0][1:0]                 entry_state_next;
  logic                               overflow;
  logic [NE-1:0]                      seen_upd;
  logic                               err_upd;

  atrm_pkg::rsp_t                     rsp_next;
  atrm_pkg::hit_t                     hit;
  logic                               take;

  assign req_ready = !rsp_valid || rsp_ready;
  assign take      = req_valid && req_ready;

  assign user_len_cap = (user_len > atrm_pkg::PAT_LEN_W'(atrm_pkg::MAX_PAT))
                        ? atrm_pkg::PAT_LEN_W'(atrm_pkg::MAX_PAT) : user_len;

  // a full line restarts before the new byte goes in
  assign overflow = (line_length >= atrm_pkg::LINE_W'(atrm_pkg::LINE_BYTES));
  assign len_inc  = (overflow ? '0 : line_length) + atrm_pkg::LINE_W'(1);

  always_comb begin
    window_shift[0] = req_data.rx_byte;
    for (int k = 1; k < atrm_pkg::WINDOW_BYTES; k++) window_shift[k] = window[k-1];
  end

  atrm_tail_cmp u_cmp (
    .win      (window_shift),
    .line_len (len_inc),
    .user_pat ({user_tail, user_head}),
    .user_len (user_len_cap),
    .hit      (hit)
  );

  assign seen_upd = (overflow ? '0 : seen_flags) | hit.seen;
  assign err_upd  = (overflow ? 1'b0 : error_flag) | hit.err;

  always_comb begin
    window_next      = window;
    line_length_next = line_length;
    first_char_next  = first_char;
    seen_flags_next  = seen_flags;
    error_flag_next  = error_flag;
    entry_state_next = entry_state;
    rsp_next         = '0;
    if (take) begin
      if (req_data.req_type == atrm_pkg::REQ_CLEAR) begin
        if (req_data.entry_index < 4'(NE)) begin
          entry_state_next[req_data.entry_index] = atrm_pkg::ST_NONE;
        end
      end else begin
        window_next      = window_shift;
        line_length_next = len_inc;
        seen_flags_next  = seen_upd;
        error_flag_next  = err_upd;
        if (len_inc == atrm_pkg::LINE_W'(1)) first_char_next = req_data.rx_byte;
        if (req_data.rx_byte == atrm_pkg::CH_PROMPT) begin
          rsp_next.prompt_seen = 1'b1;
          for (int i = 0; i < NE; i++) begin
            if (hit.prompt_mask[i]) entry_state_next[i] = atrm_pkg::ST_OK;
          end
          line_length_next = '0;
          seen_flags_next  = '0;
          error_flag_next  = 1'b0;
        end else if (len_inc >= atrm_pkg::LINE_W'(2) && req_data.rx_byte == atrm_pkg::CH_LF
                     && window[0] == atrm_pkg::CH_CR) begin
          if (len_inc >= atrm_pkg::LINE_W'(4)) begin
            rsp_next.line_done    = 1'b1;
            rsp_next.matched_mask = seen_upd;
            rsp_next.hex_line     = data_mode && (first_char_next == atrm_pkg::CH_COLON);
            for (int i = 0; i < NE; i++) begin
              if (seen_upd[i]) entry_state_next[i] = atrm_pkg::ST_OK;
              if (err_upd) entry_state_next[i] = atrm_pkg::ST_ERR;
            end
          end
          line_length_next = '0;
          seen_flags_next  = '0;
          error_flag_next  = 1'b0;
        end
      end
      rsp_next.reply_states = entry_state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      data_mode   <= 1'b0;
      user_head   <= '0;
      user_tail   <= '0;
      user_len    <= '0;
      window      <= '0;
      line_length <= '0;
      first_char  <= '0;
      seen_flags  <= '0;
      error_flag  <= 1'b0;
      entry_state <= '0;
      rsp_valid   <= 1'b0;
    end else begin
      if (wr_en) begin
        case (wr_index)
          atrm_pkg::REG_DATA_MODE: data_mode <= wr_data[0];
          atrm_pkg::REG_USER_HEAD: user_head <= wr_data;
          atrm_pkg::REG_USER_TAIL: user_tail <= wr_data;
          atrm_pkg::REG_USER_LEN:  user_len  <= wr_data[atrm_pkg::PAT_LEN_W-1:0];
          default: ;
        endcase
      end
      window      <= window_next;
      line_length <= line_length_next;
      first_char  <= first_char_next;
      seen_flags  <= seen_flags_next;
      error_flag  <= error_flag_next;
      entry_state <= entry_state_next;
      if (take) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // result payload register
  always_ff @(posedge clk) begin
    if (take) rsp_data <= rsp_next;
  end

`ifndef SYNTHESIS
  a_len_bound: assert property (@(posedge clk) disable iff (rst)
    line_length <= atrm_pkg::LINE_W'(atrm_pkg::LINE_BYTES))
    else $error("line length beyond buffer size");

  a_prompt_restart: assert property (@(posedge clk) disable iff (rst)
    take && req_data.req_type == atrm_pkg::REQ_BYTE
      && req_data.rx_byte == atrm_pkg::CH_PROMPT |=> line_length == '0 && seen_flags == '0)
    else $error("prompt did not restart the line");

  a_done_not_prompt: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_data.line_done |-> !rsp_data.prompt_seen)
    else $error("line end and prompt in one result");

  a_hex_needs_done: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp_data.hex_line || rsp_data.matched_mask != '0) |-> rsp_data.line_done)
    else $error("line flags without a completed line");
`endif

endmodule

// ===== test/at_reply_line_matcher_tb.sv =====
// self-checking bench for at_reply_line_matcher: random and directed reply traffic,
// a line-state predictor inside a scoreboard class, random stalls on both channels
// depends on atrm_pkg and the at_reply_line_matcher rtl
module at_reply_line_matcher_tb;

  localparam int STALL_LIMIT     = 3000;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int MAX_REPORTS     = 10;

  class line_match_scoreboard;
    // register copies
    bit         data_mode;
    bit [63:0]  user_head;
    bit [63:0]  user_tail;
    bit [4:0]   user_len_reg;
    // line state
    bit [7:0]   win [atrm_pkg::WINDOW_BYTES];
    int         line_len;
    bit [7:0]   first_ch;
    bit [atrm_pkg::NUM_ENTRIES-1:0] seen;
    bit         err_seen;
    atrm_pkg::reply_code_t states [atrm_pkg::NUM_ENTRIES];
    // reply strings, first character in the low byte
    string      fixed_txt [atrm_pkg::NUM_FIXED];
    bit [127:0] fixed_pat [atrm_pkg::NUM_FIXED];
    bit [127:0] error_pat;
    atrm_pkg::rsp_t expected_replies [$];
    int         errors, checked, clears_taken, prompts_taken, lines_closed, hex_lines;

    function new();
      fixed_txt = '{"OK", "SMS Ready", "CONNECT OK", ">", "SEND OK", "SHUT OK",
                    "CONNECT OK", "OK"};
      foreach (fixed_txt[i]) fixed_pat[i] = pack_text(fixed_txt[i]);
      error_pat = pack_text("ERROR");
      foreach (win[i]) win[i] = 8'h00;
      foreach (states[i]) states[i] = atrm_pkg::ST_NONE;
      first_ch = 8'h00;
      restart_line();
    endfunction

    function bit [127:0] pack_text(string s);
      bit [127:0] p;
      p = '0;
      for (int i = 0; i < s.len() && i < atrm_pkg::MAX_PAT; i++) p[8*i +: 8] = s[i];
      return p;
    endfunction

    function void restart_line();
      line_len = 0;
      seen     = '0;
      err_seen = 1'b0;
    endfunction

    function int user_len();
      return (user_len_reg > atrm_pkg::MAX_PAT) ? atrm_pkg::MAX_PAT : int'(user_len_reg);
    endfunction

    function bit [7:0] user_char(int k);
      return (k < 8) ? user_head[8*k +: 8] : user_tail[8*(k-8) +: 8];
    endfunction

    function int pending();
      return expected_replies.size();
    endfunction

    function void apply_register(logic [atrm_pkg::REG_IDX_W-1:0] idx, bit [63:0] v);
      case (idx)
        atrm_pkg::REG_DATA_MODE: data_mode    = v[0];
        atrm_pkg::REG_USER_HEAD: user_head    = v;
        atrm_pkg::REG_USER_TAIL: user_tail    = v;
        atrm_pkg::REG_USER_LEN:  user_len_reg = v[4:0];
        default: ;
      endcase
    endfunction

    // only bytes of the current line count
    function bit line_ends_with(bit [127:0] pat, int n);
      if (n == 0 || n > atrm_pkg::WINDOW_BYTES || n > line_len) return 1'b0;
      for (int k = 0; k < n; k++)
        if (win[k] != pat[8*(n-1-k) +: 8]) return 1'b0;
      return 1'b1;
    endfunction

    function void take_request(atrm_pkg::req_t r);
      atrm_pkg::rsp_t e;
      bit [127:0]     upat;
      int             ulen;
      e    = '0;
      upat = {user_tail, user_head};
      ulen = user_len();
      if (r.req_type == atrm_pkg::REQ_CLEAR) begin
        clears_taken++;
        if (r.entry_index < atrm_pkg::NUM_ENTRIES) states[r.entry_index] = atrm_pkg::ST_NONE;
      end else begin
        if (line_len >= atrm_pkg::LINE_BYTES) restart_line();
        for (int i = atrm_pkg::WINDOW_BYTES - 1; i > 0; i--) win[i] = win[i-1];
        win[0] = r.rx_byte;
        line_len++;
        if (line_len == 1) first_ch = r.rx_byte;
        for (int i = 0; i < atrm_pkg::NUM_FIXED; i++)
          if (line_ends_with(fixed_pat[i], fixed_txt[i].len())) seen[i] = 1'b1;
        if (line_ends_with(upat, ulen)) seen[atrm_pkg::USER_ENTRY] = 1'b1;
        if (line_ends_with(error_pat, 5)) err_seen = 1'b1;
        if (r.rx_byte == atrm_pkg::CH_PROMPT) begin
          e.prompt_seen = 1'b1;
          prompts_taken++;
          for (int i = 0; i < atrm_pkg::NUM_FIXED; i++)
            if (fixed_pat[i][7:0] == atrm_pkg::CH_PROMPT) states[i] = atrm_pkg::ST_OK;
          if (ulen >= 1 && upat[7:0] == atrm_pkg::CH_PROMPT)
            states[atrm_pkg::USER_ENTRY] = atrm_pkg::ST_OK;
          restart_line();
        end else if (line_len >= 2 && r.rx_byte == atrm_pkg::CH_LF
                     && win[1] == atrm_pkg::CH_CR) begin
          // shorter lines are dropped without a line_done flag
          if (line_len >= 4) begin
            e.line_done    = 1'b1;
            e.matched_mask = seen;
            e.hex_line     = data_mode && (first_ch == atrm_pkg::CH_COLON);
            lines_closed++;
            if (e.hex_line) hex_lines++;
            for (int i = 0; i < atrm_pkg::NUM_ENTRIES; i++) begin
              if (seen[i]) states[i] = atrm_pkg::ST_OK;
              if (err_seen) states[i] = atrm_pkg::ST_ERR;
            end
          end
          restart_line();
        end
      end
      for (int i = 0; i < atrm_pkg::NUM_ENTRIES; i++) e.reply_states[2*i +: 2] = states[i];
      expected_replies.push_back(e);
    endfunction

    function void check_reply(atrm_pkg::rsp_t got);
      atrm_pkg::rsp_t e;
      checked++;
      if (expected_replies.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("reply %0d arrived with no request waiting: %h", checked, got);
        return;
      end
      e = expected_replies.pop_front();
      if (got.reply_states !== e.reply_states || got.line_done !== e.line_done ||
          got.prompt_seen !== e.prompt_seen || got.hex_line !== e.hex_line ||
          got.matched_mask !== e.matched_mask) begin
        errors++;
        if (errors <= MAX_REPORTS) begin
          $display("reply %0d: expected states=%h done=%b prompt=%b hex=%b mask=%h",
                   checked, e.reply_states, e.line_done, e.prompt_seen, e.hex_line,
                   e.matched_mask);
          $display("reply %0d: got      states=%h done=%b prompt=%b hex=%b mask=%h",
                   checked, got.reply_states, got.line_done, got.prompt_seen,
                   got.hex_line, got.matched_mask);
        end
      end
    endfunction
  endclass

  logic                           clk = 1'b0;
  logic                           rst = 1'b1;
  logic                           req_valid = 1'b0;
  logic                           req_ready;
  atrm_pkg::req_t                 req_data = '0;
  logic                           rsp_valid;
  logic                           rsp_ready = 1'b0;
  atrm_pkg::rsp_t                 rsp_data;
  logic                           wr_en = 1'b0;
  logic [atrm_pkg::REG_IDX_W-1:0] wr_index = '0;
  logic [atrm_pkg::CFG_W-1:0]     wr_data = '0;

  line_match_scoreboard board;
  int  items_sent;
  int  settings_used;
  bit  calm;
  bit  hold_off_req;

  at_reply_line_matcher dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req_data  (req_data),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp_data  (rsp_data),
    .wr_en     (wr_en),
    .wr_index  (wr_index),
    .wr_data   (wr_data)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // mostly short gaps, now and then a long one
  function automatic int gap_length();
    return ($urandom_range(0, 99) < 85) ? $urandom_range(1, 3) : $urandom_range(8, 30);
  endfunction

  function automatic bit [7:0] printable();
    return 8'($urandom_range(32, 126));
  endfunction

  // valid is left high after the transfer; the next call or settle() decides
  task automatic send_req(input atrm_pkg::req_t r);
    int gap;
    gap = (calm || $urandom_range(0, 99) < 60) ? 0 : gap_length();
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_valid <= 1'b1;
    req_data  <= r;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    board.take_request(r);
    items_sent++;
  endtask

  task automatic send_byte(input bit [7:0] b);
    atrm_pkg::req_t r;
    r.req_type    = atrm_pkg::REQ_BYTE;
    r.rx_byte     = b;
    r.entry_index = 4'($urandom_range(0, 15));
    send_req(r);
  endtask

  task automatic send_clear(input bit [3:0] idx);
    atrm_pkg::req_t r;
    r.req_type    = atrm_pkg::REQ_CLEAR;
    r.rx_byte     = 8'($urandom_range(0, 255));
    r.entry_index = idx;
    send_req(r);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  // one reply string, fixed, user or error, optionally missing its last character
  task automatic send_pattern(input int pick, input int cut);
    string s;
    int    n;
    if (pick == atrm_pkg::NUM_FIXED && board.user_len() > 0) begin
      n = board.user_len() - cut;
      for (int k = 0; k < n; k++) send_byte(board.user_char(k));
    end else begin
      s = (pick < atrm_pkg::NUM_FIXED) ? board.fixed_txt[pick] : "ERROR";
      n = s.len() - cut;
      for (int k = 0; k < n; k++) send_byte(s[k]);
    end
  endtask

  task automatic random_traffic(input int count);
    int stop_at;
    int r;
    stop_at = items_sent + count;
    while (items_sent < stop_at) begin
      r = $urandom_range(0, 99);
      if (r < 8) begin
        send_clear(4'($urandom_range(0, 15)));
      end else if (r < 16) begin
        repeat ($urandom_range(0, 2)) send_byte(printable());
        send_byte(atrm_pkg::CH_PROMPT);
      end else if (r < 24) begin
        repeat ($urandom_range(1, 6)) send_byte(8'($urandom_range(0, 255)));
      end else if (r < 32) begin
        repeat ($urandom_range(0, 2)) send_byte(printable());
        send_byte(atrm_pkg::CH_CR);
        send_byte(atrm_pkg::CH_LF);
      end else begin
        if ($urandom_range(0, 3) == 0) send_byte(atrm_pkg::CH_COLON);
        repeat ($urandom_range(0, 3)) send_byte(printable());
        send_pattern($urandom_range(0, 9), ($urandom_range(0, 7) == 0) ? 1 : 0);
        if ($urandom_range(0, 3) == 0) send_pattern($urandom_range(0, 9), 0);
        repeat ($urandom_range(0, 2)) send_byte(printable());
        send_byte(atrm_pkg::CH_CR);
        send_byte(atrm_pkg::CH_LF);
      end
    end
  endtask

  task automatic settle();
    req_valid <= 1'b0;
    while (board.pending() > 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_register(input logic [atrm_pkg::REG_IDX_W-1:0] idx,
                                input bit [63:0] v);
    wr_en    <= 1'b1;
    wr_index <= idx;
    wr_data  <= v;
    @(posedge clk);
    wr_en    <= 1'b0;
    board.apply_register(idx, v);
    @(posedge clk);
  endtask

  // unused upper bits of the mode and length registers get random filler
  task automatic set_matcher(input bit dm, input bit [127:0] pat, input bit [4:0] len);
    bit [63:0] v;
    v = {$urandom, $urandom};
    v[0] = dm;
    write_register(atrm_pkg::REG_DATA_MODE, v);
    write_register(atrm_pkg::REG_USER_HEAD, pat[63:0]);
    write_register(atrm_pkg::REG_USER_TAIL, pat[127:64]);
    v = {$urandom, $urandom};
    v[4:0] = len;
    write_register(atrm_pkg::REG_USER_LEN, v);
    settings_used++;
  endtask

  // response side: random stalls plus the long hold-off on request
  initial begin : reply_side
    int stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (rsp_valid && rsp_ready) board.check_reply(rsp_data);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        stall_left   = HOLD_OFF_CYCLES;
      end
      if (stall_left > 0) begin
        stall_left--;
        rsp_ready <= 1'b0;
      end else if (calm || $urandom_range(0, 99) < 75) begin
        rsp_ready <= 1'b1;
      end else begin
        stall_left = gap_length() - 1;
        rsp_ready <= 1'b0;
      end
    end
  end

  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("no transfer for %0d cycles", STALL_LIMIT);
    $display("at_reply_line_matcher: mismatch");
    $finish;
  end

  initial begin : stimulus
    board = new();
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // directed: leading lone LF, prompt, error line, clears, short line, hex line
    set_matcher(1'b1, board.pack_text("RDY"), 5'd3);
    send_text("\nOK\r\n");
    send_byte(atrm_pkg::CH_PROMPT);
    send_text("ERROR\r\n");
    send_clear(4'd0);
    send_clear(4'd8);
    send_clear(4'd15);
    send_text("A\r\n");
    send_text(":RDY\r\n");
    settle();

    // user entry joins the prompt; receiver holds off so the block backs up
    set_matcher(1'b0, board.pack_text(">SEND"), 5'd5);
    hold_off_req = 1'b1;
    random_traffic(70);
    settle();

    // longest user string, with a pause until everything has drained
    set_matcher(1'b1, board.pack_text("ABCDEFGHIJKLMNOP"), 5'd16);
    random_traffic(35);
    settle();
    random_traffic(35);
    settle();

    // length field above the limit acts as the limit; no idling here
    set_matcher(1'b1, board.pack_text("ABCDEFGHIJKLMNOP"), 5'd31);
    calm = 1'b1;
    random_traffic(70);
    settle();
    calm = 1'b0;

    set_matcher(1'b0, {$urandom, $urandom, $urandom, $urandom}, 5'd0);
    random_traffic(70);
    settle();

    set_matcher(1'b1, '1, 5'd31);
    random_traffic(70);
    settle();

    set_matcher(1'b1, board.pack_text(">"), 5'd1);
    random_traffic(70);
    settle();

    // line length wrap: exact-size line, CR LF split by the wrap, wrap mid-line
    set_matcher(1'b1, {$urandom, $urandom, $urandom, $urandom}, 5'($urandom_range(0, 31)));
    send_text("OK");
    repeat (atrm_pkg::LINE_BYTES - 4) send_byte(8'($urandom_range(97, 122)));
    send_text("\r\n");
    send_text("OK");
    repeat (atrm_pkg::LINE_BYTES - 3) send_byte(8'($urandom_range(97, 122)));
    send_text("\r\nab\r\n");
    repeat (atrm_pkg::LINE_BYTES + 14) send_byte(8'($urandom_range(97, 122)));
    send_text("OK\r\n");
    settle();

    set_matcher(1'($urandom_range(0, 1)), {$urandom, $urandom, $urandom, $urandom},
                5'($urandom_range(0, 31)));
    random_traffic(70);
    settle();

    $display("covered %0d requests: %0d clears, %0d prompts, %0d closed lines (%0d hex)",
             items_sent, board.clears_taken, board.prompts_taken, board.lines_closed,
             board.hex_lines);
    $display("%0d register settings, %0d replies checked, %0d bad, %0d still waiting",
             settings_used, board.checked, board.errors, board.pending());
    if (board.errors == 0 && board.pending() == 0)
      $display("at_reply_line_matcher: match");
    else
      $display("at_reply_line_matcher: mismatch");
    $finish;
  end

endmodule
